// File: rtl/core/color_command_message_parser_defines.svh
// Assertion macros shared by the parser RTL.
// Each expands to one labeled concurrent assertion on i_clk, off during reset.
`ifndef COLOR_COMMAND_MESSAGE_PARSER_DEFINES_SVH
`define COLOR_COMMAND_MESSAGE_PARSER_DEFINES_SVH

// Same-cycle implication.
`define CCMP_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define CCMP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/core/ccmp_pkg.sv
package ccmp_pkg;

    // Field widths
    localparam int OUT_WIDTH           = 8;
    localparam int CHAR_WIDTH          = 8;
    localparam int KIND_WIDTH          = 2;
    localparam int NUM_SLOTS           = 4;
    localparam int SLOT_IDX_WIDTH      = 3;
    localparam int DEFAULT_VALUE_WIDTH = 8;

    // Decimal accumulation
    localparam int RADIX      = 10;
    localparam int DIGIT_BASE = 48;

    // Character codes
    localparam logic [CHAR_WIDTH-1:0] CH_COLOR  = 8'h6F; // 'o'
    localparam logic [CHAR_WIDTH-1:0] CH_SEND   = 8'h73; // 's'
    localparam logic [CHAR_WIDTH-1:0] CH_REMOVE = 8'h72; // 'r'
    localparam logic [CHAR_WIDTH-1:0] CH_STATUS = 8'h63; // 'c'
    localparam logic [CHAR_WIDTH-1:0] CH_DASH   = 8'h2D; // '-'
    localparam logic [CHAR_WIDTH-1:0] CH_DOT    = 8'h2E; // '.'

    // Message kinds
    localparam logic [KIND_WIDTH-1:0] KIND_COLOR  = 2'd0;
    localparam logic [KIND_WIDTH-1:0] KIND_SEND   = 2'd1;
    localparam logic [KIND_WIDTH-1:0] KIND_REMOVE = 2'd2;
    localparam logic [KIND_WIDTH-1:0] KIND_STATUS = 2'd3;

    typedef struct packed {
        logic [CHAR_WIDTH-1:0] char_code;
        logic                  first_char;
        logic                  last_char;
    } t_in_word;

    typedef struct packed {
        logic [KIND_WIDTH-1:0] kind;
        logic                  ok;
        logic [OUT_WIDTH-1:0]  first_value;
        logic [OUT_WIDTH-1:0]  second_value;
        logic [OUT_WIDTH-1:0]  third_value;
        logic [OUT_WIDTH-1:0]  fourth_value;
        logic [OUT_WIDTH-1:0]  last_value;
    } t_out_word;

    typedef struct packed {
        logic      valid;
        t_out_word word;
    } t_res_push;

endpackage

// File: rtl/core/color_command_message_parser.sv
// Color and command message parser.
// Input channel (i_in_valid / o_in_ready / i_in_data) takes one character word
// per cycle while ready; first_char marks the kind letter, last_char the end of the buffer.
// Output channel (o_out_valid / i_out_ready / o_out_data) gives at most one
// result word per message: success at the '.', or failure at the buffer end.
// Throughput: one input word per cycle while o_in_ready is high, set by the
// combinational multiply-add of the decimal accumulator and the state update in the parser.
// Result path: a result word is registered in the main output register, or parked
// in the skid register while the main register is stalled, before it drives the output.
// The output holds a main register and a one-word skid register. Input stays
// ready while a result waits, until both are full; a stalled receiver then
// drops o_in_ready until the main register drains.
// Reset (synchronous, active low) closes any open message, clears the
// accumulator and the value slots, and empties the output registers.
`include "color_command_message_parser_defines.svh"

module color_command_message_parser #(
    parameter int VALUE_WIDTH = ccmp_pkg::DEFAULT_VALUE_WIDTH
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  ccmp_pkg::t_in_word  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output ccmp_pkg::t_out_word o_out_data
);
    import ccmp_pkg::*;

    logic      in_fire;
    t_res_push push;

    assign in_fire = i_in_valid & o_in_ready;

    // Parse one word per cycle while the output queue is ready
    ccmp_parser #(
        .VALUE_WIDTH(VALUE_WIDTH)
    ) u_parser (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_fire (in_fire),
        .i_word (i_in_data),
        .o_push (push)
    );

    // Hold results for the receiver
    ccmp_out_q u_out_q (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .o_ready(o_in_ready),
        .o_valid(o_out_valid),
        .i_ready(i_out_ready),
        .o_data (o_out_data)
    );

    `CCMP_ASSERT_NOW(a_stall_has_result, !o_in_ready, o_out_valid, "input stalled with no result pending")
    `CCMP_ASSERT_NOW(a_fail_zero_last, o_out_valid && !o_out_data.ok, o_out_data.last_value == '0, "failure result with nonzero last value")
    `CCMP_ASSERT_NOW(a_cmd_no_slots, o_out_valid && o_out_data.kind != KIND_COLOR, o_out_data.first_value == '0 && o_out_data.second_value == '0 && o_out_data.third_value == '0 && o_out_data.fourth_value == '0, "command result carries slot values")
    `CCMP_ASSERT_NEXT(a_single_char_result, in_fire && i_in_data.first_char && i_in_data.last_char, o_out_valid, "single-character buffer gave no result")

endmodule

// File: rtl/core/ccmp_parser.sv
module ccmp_parser #(
    parameter int VALUE_WIDTH = ccmp_pkg::DEFAULT_VALUE_WIDTH
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_fire,
    input  ccmp_pkg::t_in_word  i_word,
    output ccmp_pkg::t_res_push o_push
);
    import ccmp_pkg::*;

    localparam int ACC_EXT_WIDTH = VALUE_WIDTH + CHAR_WIDTH;
    localparam int SLOT_ADDR_W   = $clog2(NUM_SLOTS);
    localparam logic [SLOT_IDX_WIDTH-1:0] SLOT_LAST = SLOT_IDX_WIDTH'(NUM_SLOTS - 1);
    localparam logic [SLOT_IDX_WIDTH-1:0] SLOT_FULL = SLOT_IDX_WIDTH'(NUM_SLOTS);

    // Low output bits of a value, zero-extended when values are narrow
    function automatic logic [OUT_WIDTH-1:0] f_out(input logic [VALUE_WIDTH-1:0] v);
        logic [VALUE_WIDTH+OUT_WIDTH-1:0] w;
        w = {{OUT_WIDTH{1'b0}}, v};
        return w[OUT_WIDTH-1:0];
    endfunction

    logic                      r_busy, n_busy;
    logic [KIND_WIDTH-1:0]     r_kind, n_kind;
    logic                      r_kind_valid, n_kind_valid;
    logic [SLOT_IDX_WIDTH-1:0] r_slot_idx, n_slot_idx;
    logic [VALUE_WIDTH-1:0]    r_acc, n_acc;
    logic [VALUE_WIDTH-1:0]    r_slot [NUM_SLOTS];
    logic [VALUE_WIDTH-1:0]    n_slot [NUM_SLOTS];
    logic                      r_finished, n_finished;

    logic                      done;
    logic [SLOT_ADDR_W-1:0]    slot_addr;
    logic [ACC_EXT_WIDTH-1:0]  acc_sum;
    t_res_push                 push;

    // Accumulate one decimal digit, wrapping at the value width
    assign acc_sum = ACC_EXT_WIDTH'(r_acc) * ACC_EXT_WIDTH'(RADIX)
                   + ACC_EXT_WIDTH'(i_word.char_code) - ACC_EXT_WIDTH'(DIGIT_BASE);

    // Saturate the slot write address at the last slot
    assign slot_addr = (r_slot_idx < SLOT_LAST) ? r_slot_idx[SLOT_ADDR_W-1:0]
                                                : SLOT_LAST[SLOT_ADDR_W-1:0];

    // Next state and result for one accepted word
    always_comb begin
        n_busy       = r_busy;
        n_kind       = r_kind;
        n_kind_valid = r_kind_valid;
        n_slot_idx   = r_slot_idx;
        n_acc        = r_acc;
        n_finished   = r_finished;
        for (int i = 0; i < NUM_SLOTS; i++) begin
            n_slot[i] = r_slot[i];
        end
        done = r_finished;
        push = '0;

        if (i_fire) begin
            if (i_word.first_char) begin
                // Open a new message, dropping any message in progress
                n_busy       = 1'b1;
                n_finished   = 1'b0;
                n_acc        = '0;
                n_slot_idx   = '0;
                n_kind_valid = 1'b1;
                for (int i = 0; i < NUM_SLOTS; i++) begin
                    n_slot[i] = '0;
                end
                unique case (i_word.char_code)
                    CH_COLOR:  n_kind = KIND_COLOR;
                    CH_SEND:   n_kind = KIND_SEND;
                    CH_REMOVE: n_kind = KIND_REMOVE;
                    CH_STATUS: n_kind = KIND_STATUS;
                    default: begin
                        n_kind       = KIND_COLOR;
                        n_kind_valid = 1'b0;
                    end
                endcase
                // Single-character buffer fails at once
                if (i_word.last_char) begin
                    n_busy          = 1'b0;
                    push.valid      = 1'b1;
                    push.word.kind  = n_kind_valid ? n_kind : KIND_COLOR;
                    push.word.ok    = 1'b0;
                end
            end else if (r_busy) begin
                if (!r_finished && r_kind_valid) begin
                    if (i_word.char_code == CH_DOT) begin
                        // Emit success with the final value
                        n_finished              = 1'b1;
                        done                    = 1'b1;
                        push.valid              = 1'b1;
                        push.word.kind          = r_kind;
                        push.word.ok            = 1'b1;
                        push.word.first_value   = f_out(r_slot[0]);
                        push.word.second_value  = f_out(r_slot[1]);
                        push.word.third_value   = f_out(r_slot[2]);
                        push.word.fourth_value  = f_out(r_slot[3]);
                        push.word.last_value    = f_out(r_acc);
                    end else if (i_word.char_code == CH_DASH && r_kind == KIND_COLOR) begin
                        // Store the value into the next slot
                        n_slot[slot_addr] = r_acc;
                        if (r_slot_idx < SLOT_FULL) begin
                            n_slot_idx = r_slot_idx + 1'b1;
                        end
                        n_acc = '0;
                    end else begin
                        n_acc = acc_sum[VALUE_WIDTH-1:0];
                    end
                end
                // Close the buffer; fail if no terminator was seen
                if (i_word.last_char) begin
                    n_busy = 1'b0;
                    if (!done) begin
                        push.valid             = 1'b1;
                        push.word.ok           = 1'b0;
                        push.word.last_value   = '0;
                        if (r_kind_valid) begin
                            push.word.kind         = r_kind;
                            push.word.first_value  = f_out(n_slot[0]);
                            push.word.second_value = f_out(n_slot[1]);
                            push.word.third_value  = f_out(n_slot[2]);
                            push.word.fourth_value = f_out(n_slot[3]);
                        end
                    end
                end
            end
        end
    end

    // Hold message state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy       <= 1'b0;
            r_kind       <= KIND_COLOR;
            r_kind_valid <= 1'b0;
            r_slot_idx   <= '0;
            r_acc        <= '0;
            r_finished   <= 1'b0;
            for (int i = 0; i < NUM_SLOTS; i++) begin
                r_slot[i] <= '0;
            end
        end else begin
            r_busy       <= n_busy;
            r_kind       <= n_kind;
            r_kind_valid <= n_kind_valid;
            r_slot_idx   <= n_slot_idx;
            r_acc        <= n_acc;
            r_finished   <= n_finished;
            for (int i = 0; i < NUM_SLOTS; i++) begin
                r_slot[i] <= n_slot[i];
            end
        end
    end

    assign o_push = push;

endmodule

// File: rtl/core/ccmp_out_q.sv
module ccmp_out_q (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  ccmp_pkg::t_res_push i_push,
    output logic                o_ready,
    output logic                o_valid,
    input  logic                i_ready,
    output ccmp_pkg::t_out_word o_data
);
    import ccmp_pkg::*;

    logic      r_main_valid, n_main_valid;
    logic      r_skid_valid, n_skid_valid;
    t_out_word r_main, n_main;
    t_out_word r_skid, n_skid;
    logic      pop;

    assign pop = r_main_valid & i_ready;

    // Fill the main register first, park in the skid when it is stalled
    always_comb begin
        n_main_valid = r_main_valid;
        n_skid_valid = r_skid_valid;
        n_main       = r_main;
        n_skid       = r_skid;
        if (pop) begin
            n_main_valid = r_skid_valid;
            n_main       = r_skid;
            n_skid_valid = 1'b0;
        end
        if (i_push.valid) begin
            if (!r_main_valid || pop) begin
                n_main_valid = 1'b1;
                n_main       = i_push.word;
            end else begin
                n_skid_valid = 1'b1;
                n_skid       = i_push.word;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_main_valid <= n_main_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_main <= n_main;
        r_skid <= n_skid;
    end

    assign o_ready = ~r_skid_valid;
    assign o_valid = r_main_valid;
    assign o_data  = r_main;

endmodule

// File: verif/tb_top.sv
module tb_top;
    import ccmp_pkg::*;

    logic      i_clk;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    logic      o_in_ready;
    t_in_word  i_in_data   = '0;
    logic      o_out_valid;
    logic      i_out_ready = 1'b0;
    t_out_word o_out_data;

    // Character words waiting to be offered, and results still owed by the parser
    t_in_word  pending_chars[$];
    t_out_word expected_results[$];

    bit word_offered     = 1'b0;
    int sender_idle_pct  = 0;
    int recv_stall_pct   = 0;
    int hold_left        = 0;
    int mismatch_count   = 0;

    // Parser shadow state
    logic                      msg_open;
    logic                      kind_known;
    logic                      msg_done;
    logic [KIND_WIDTH-1:0]     msg_kind_q;
    logic [SLOT_IDX_WIDTH-1:0] slot_idx;
    logic [OUT_WIDTH-1:0]      acc_q;
    logic [OUT_WIDTH-1:0]      slot_q [NUM_SLOTS];

    color_command_message_parser uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Build a result word from the current message; a bad kind letter zeroes its kind and slot values
    function automatic t_out_word form_result(logic ok, logic [OUT_WIDTH-1:0] last);
        t_out_word r;
        r.kind         = kind_known ? msg_kind_q : KIND_COLOR;
        r.ok           = ok;
        r.first_value  = kind_known ? slot_q[0] : '0;
        r.second_value = kind_known ? slot_q[1] : '0;
        r.third_value  = kind_known ? slot_q[2] : '0;
        r.fourth_value = kind_known ? slot_q[3] : '0;
        r.last_value   = last;
        return r;
    endfunction

    // Advance the shadow parser by one accepted character word
    task automatic parse_word(input t_in_word w);
        logic [SLOT_IDX_WIDTH-1:0] k;
        if (w.first_char) begin
            msg_open   = 1'b1;
            msg_done   = 1'b0;
            acc_q      = '0;
            slot_idx   = '0;
            for (int i = 0; i < NUM_SLOTS; i++) slot_q[i] = '0;
            kind_known = 1'b1;
            case (w.char_code)
                CH_COLOR:  msg_kind_q = KIND_COLOR;
                CH_SEND:   msg_kind_q = KIND_SEND;
                CH_REMOVE: msg_kind_q = KIND_REMOVE;
                CH_STATUS: msg_kind_q = KIND_STATUS;
                default: begin
                    msg_kind_q = KIND_COLOR;
                    kind_known = 1'b0;
                end
            endcase
            // one-character buffer fails at once
            if (w.last_char) begin
                expected_results.push_back(form_result(1'b0, '0));
                msg_open = 1'b0;
            end
        end else if (msg_open) begin
            if (!msg_done && kind_known) begin
                if (w.char_code == CH_DOT) begin
                    expected_results.push_back(form_result(1'b1, acc_q));
                    msg_done = 1'b1;
                end else if (w.char_code == CH_DASH && msg_kind_q == KIND_COLOR) begin
                    // extra dashes keep landing in the last slot
                    k = (slot_idx < 3) ? slot_idx : 3'd3;
                    slot_q[k[1:0]] = acc_q;
                    if (slot_idx < 4) slot_idx = slot_idx + 1'b1;
                    acc_q = '0;
                end else begin
                    acc_q = OUT_WIDTH'(int'(acc_q) * RADIX + int'(w.char_code) - DIGIT_BASE);
                end
            end
            if (w.last_char) begin
                msg_open = 1'b0;
                if (!msg_done) expected_results.push_back(form_result(1'b0, '0));
            end
        end
    endtask

    // Compare one delivered result word against the oldest expectation
    task automatic check_result(input t_out_word got);
        t_out_word want;
        if (expected_results.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("unexpected result word: %p", got);
        end else begin
            want = expected_results.pop_front();
            if (want.kind !== got.kind || want.ok !== got.ok ||
                want.first_value !== got.first_value ||
                want.second_value !== got.second_value ||
                want.third_value !== got.third_value ||
                want.fourth_value !== got.fourth_value ||
                want.last_value !== got.last_value) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("result mismatch at %0t: expected %p, got %p", $time, want, got);
            end
        end
    endtask

    function automatic void push_char(logic [7:0] ch, logic first, logic last);
        t_in_word w;
        w.char_code  = ch;
        w.first_char = first;
        w.last_char  = last;
        pending_chars.push_back(w);
    endfunction

    // Queue a text as one buffer; leave it open when close is low
    function automatic void push_text(string s, logic close);
        for (int i = 0; i < s.len(); i++)
            push_char(8'(s[i]), i == 0, close && (i == s.len() - 1));
    endfunction

    // Queue one random message, mostly well formed, and count its words
    task automatic queue_message(output int n);
        logic [7:0] body[$];
        int         r;
        int         n_fields;
        int         n_digits;
        bit         left_open;
        // stray words while no message is open
        if ($urandom_range(0, 99) < 6) begin
            repeat ($urandom_range(1, 2)) push_char(8'($urandom), 1'b0, 1'($urandom));
        end
        r = $urandom_range(0, 99);
        if (r < 8)       body.push_back(8'($urandom));
        else if (r < 50) body.push_back(CH_COLOR);
        else if (r < 64) body.push_back(CH_SEND);
        else if (r < 78) body.push_back(CH_REMOVE);
        else             body.push_back(CH_STATUS);
        n_fields = $urandom_range(0, 6);
        for (int f = 0; f < n_fields; f++) begin
            n_digits = $urandom_range(0, 3);
            for (int d = 0; d < n_digits; d++) begin
                if ($urandom_range(0, 9) < 9) body.push_back(8'(DIGIT_BASE + $urandom_range(0, 9)));
                else                          body.push_back(8'($urandom));
            end
            if (f < n_fields - 1) body.push_back(CH_DASH);
        end
        if ($urandom_range(0, 99) < 85) begin
            body.push_back(CH_DOT);
            repeat ($urandom_range(0, 3)) body.push_back(8'($urandom));
        end
        // an open buffer gets dropped by the next kind letter
        left_open = ($urandom_range(0, 99) < 5);
        for (int i = 0; i < body.size(); i++)
            push_char(body[i], i == 0, !left_open && (i == body.size() - 1));
        n = body.size();
    endtask

    task automatic queue_random_chars(input int target);
        int total;
        int n;
        total = 0;
        while (total < target) begin
            queue_message(n);
            total += n;
        end
    endtask

    task automatic wait_drained();
        while (pending_chars.size() != 0 || word_offered) @(posedge i_clk);
    endtask

    // Drive: offer the next word at the falling edge, hold it until taken
    always @(negedge i_clk) begin
        if (i_rst_n && !word_offered) begin
            if (pending_chars.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
                i_in_data    <= pending_chars.pop_front();
                i_in_valid   <= 1'b1;
                word_offered = 1'b1;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Stall the output side at random, or for a counted hold-off
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else if (hold_left > 0) begin
            i_out_ready <= 1'b0;
            hold_left = hold_left - 1;
        end else begin
            i_out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // Sample both handshakes at the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                parse_word(i_in_data);
                word_offered = 1'b0;
            end
            if (o_out_valid && i_out_ready) check_result(o_out_data);
        end
    end

    initial begin
        msg_open   = 1'b0;
        kind_known = 1'b0;
        msg_done   = 1'b0;
        msg_kind_q = KIND_COLOR;
        slot_idx   = '0;
        acc_q      = '0;
        for (int i = 0; i < NUM_SLOTS; i++) slot_q[i] = '0;

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed buffers: lone letter, wrap and extra dashes, dash in a command,
        // bad letter, stray word, restart mid message
        sender_idle_pct = 0;
        recv_stall_pct  = 0;
        push_text("o", 1'b1);
        push_text("o255-999----7.z", 1'b1);
        push_text("s-", 1'b1);
        push_text("q.", 1'b1);
        push_char(8'hFF, 1'b0, 1'b1);
        push_text("r5", 1'b0);
        push_text("c.", 1'b1);

        // hold the output off long enough to back up the input
        hold_left = 300;
        queue_random_chars(150);
        wait_drained();

        sender_idle_pct = 57;
        recv_stall_pct  = 0;
        queue_random_chars(150);
        wait_drained();

        sender_idle_pct = 0;
        recv_stall_pct  = 57;
        queue_random_chars(150);
        wait_drained();

        sender_idle_pct = 15;
        recv_stall_pct  = 15;
        queue_random_chars(150);
        wait_drained();

        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        if (mismatch_count == 0 && expected_results.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    // Bound the run
    initial begin
        #2000000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
